// ===== rtl/bop_pkg.sv =====
// Shared types, constants and state codes for the binomial option pricer.
package bop_pkg;

    // Value and factor widths (unsigned Q20.24 values, 32-bit factors).
    localparam int VAL_W   = 44;
    localparam int SUM_W   = VAL_W + 1;
    localparam int FACT_W  = 32;
    localparam int LO_W    = 23;
    localparam int HI_W    = SUM_W - LO_W;
    localparam int PROD_W  = SUM_W + FACT_W;

    // Tree size.
    localparam int MAX_STEPS = 1024;
    localparam int ADDR_W    = $clog2(MAX_STEPS);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int STEPS_W   = 11;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_UP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HDISC = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS = 2'd3;

    // Register reset values.
    localparam logic [FACT_W-1:0]  UP_RESET    = 32'h4000_0000;
    localparam logic [FACT_W-1:0]  DOWN_RESET  = 32'h8000_0000;
    localparam logic [FACT_W-1:0]  HDISC_RESET = 32'h8000_0000;
    localparam logic [STEPS_W-1:0] STEPS_RESET = 11'd1;

    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

    // Stream widths.
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 48;

    // Fraction bits of the factor used by a multiply.
    typedef enum logic [1:0] {
        SH_UP,
        SH_DOWN,
        SH_DISC
    } shift_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DOWN,
        ST_DOWN_W,
        ST_UP1,
        ST_UP1_W,
        ST_UP2,
        ST_UP2_W,
        ST_LEAF,
        ST_LVL,
        ST_LEFT,
        ST_RD,
        ST_SUM,
        ST_NODE_W,
        ST_DONE
    } state_t;

    // Active configuration seen by the sequencer.
    typedef struct packed {
        logic [FACT_W-1:0] up;
        logic [FACT_W-1:0] down;
        logic [FACT_W-1:0] hdisc;
        logic [CNT_W-1:0]  n;
    } cfg_t;

    // Node memory access.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [VAL_W-1:0]  wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    // Multiplier request and response.
    typedef struct packed {
        logic              start;
        shift_t            sh;
        logic [SUM_W-1:0]  a;
        logic [FACT_W-1:0] f;
    } mul_req_t;

    typedef struct packed {
        logic             done;
        logic             sat;
        logic [VAL_W-1:0] value;
    } mul_rsp_t;

endpackage

// ===== rtl/bop_node_ram.sv =====
// Node value memory: one write port, one registered read port.
module bop_node_ram (
    input  logic                          clk,
    input  bop_pkg::ram_req_t             req,
    output logic [bop_pkg::VAL_W-1:0]     rdata
);
    import bop_pkg::*;

    logic [VAL_W-1:0] mem [MAX_STEPS];
    logic [VAL_W-1:0] rdata_reg;

    // Write and read in the same clocked block; read data arrives next cycle.
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bop_mul.sv =====
// Pipelined fixed-point multiplier with right shift and 44-bit saturation.
module bop_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  bop_pkg::mul_req_t  req,
    output bop_pkg::mul_rsp_t  rsp
);
    import bop_pkg::*;

    logic                      v1_reg;
    logic                      v2_reg;
    logic                      done_reg;
    logic [LO_W+FACT_W-1:0]    plo_reg;
    logic [HI_W-1:0]           ahi_reg;
    logic [FACT_W-1:0]         f_reg;
    shift_t                    sh1_reg;
    shift_t                    sh2_reg;
    logic [HI_W+FACT_W-1:0]    phi_reg;
    logic [VAL_W-1:0]          value_reg;
    logic                      sat_reg;
    logic [PROD_W-1:0]         full;
    logic [PROD_W-1:0]         shifted;
    logic                      sat;

    // Stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= req.start;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    // Low partial product, then high partial product, then the saturated result.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            plo_reg <= req.a[LO_W-1:0] * req.f;
            ahi_reg <= req.a[SUM_W-1:LO_W];
            f_reg   <= req.f;
            sh1_reg <= req.sh;
        end
        if (v1_reg)
        begin
            phi_reg <= ahi_reg * f_reg;
            sh2_reg <= sh1_reg;
        end
        if (v2_reg)
        begin
            value_reg <= sat ? VAL_MAX : shifted[VAL_W-1:0];
            sat_reg   <= sat;
        end
    end

    // Combine the partial products, drop the fraction bits, saturate.
    always_comb
    begin
        full = {phi_reg, {LO_W{1'b0}}} + {{(PROD_W-LO_W-FACT_W){1'b0}}, plo_reg};
        case (sh2_reg)
            SH_UP:   shifted = full >> 30;
            SH_DOWN: shifted = full >> 31;
            SH_DISC: shifted = full >> 32;
            default: shifted = full >> 32;
        endcase
        sat = |shifted[PROD_W-1:VAL_W];
    end

    assign rsp.done  = done_reg;
    assign rsp.sat   = sat_reg;
    assign rsp.value = value_reg;

endmodule

// ===== rtl/bop_core.sv =====
// Sequencer: builds the leaves, runs backward induction through the node memory.
module bop_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bop_pkg::cfg_t               cfg,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [bop_pkg::VAL_W-1:0]   spot,
    input  logic [bop_pkg::VAL_W-1:0]   strike,
    output logic                        res_valid,
    input  logic                        res_ready,
    output logic [bop_pkg::VAL_W-1:0]   res_value,
    output logic                        res_ovf
);
    import bop_pkg::*;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [ADDR_W-1:0]  idx_reg;
    logic [ADDR_W-1:0]  lvl_reg;
    logic [VAL_W-1:0]   p_reg;
    logic [VAL_W-1:0]   strike_reg;
    logic [VAL_W-1:0]   left_reg;
    logic [VAL_W-1:0]   right_reg;
    logic [VAL_W-1:0]   last_reg;
    logic               ovf_reg;

    ram_req_t           ram_req;
    logic [VAL_W-1:0]   rdata;
    mul_req_t           mul_req;
    mul_rsp_t           mul_rsp;

    logic [CNT_W-1:0]   n_m1;
    logic [VAL_W-1:0]   leaf_val;
    logic               leaf_last;
    logic               node_last;

    bop_node_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (rdata)
    );

    bop_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    assign n_m1      = cfg.n - CNT_W'(1);
    assign leaf_val  = (p_reg > strike_reg) ? (p_reg - strike_reg) : '0;
    assign leaf_last = ({1'b0, idx_reg} == n_m1);
    assign node_last = (({1'b0, idx_reg} + CNT_W'(1)) == {1'b0, lvl_reg});

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_DOWN;
            ST_DOWN:   state_next = (cnt_reg == n_m1) ? ST_LEAF : ST_DOWN_W;
            ST_DOWN_W: if (mul_rsp.done) state_next = ST_DOWN;
            ST_UP1:    state_next = ST_UP1_W;
            ST_UP1_W:  if (mul_rsp.done) state_next = ST_UP2;
            ST_UP2:    state_next = ST_UP2_W;
            ST_UP2_W:  if (mul_rsp.done) state_next = ST_LEAF;
            ST_LEAF:
            begin
                if (!leaf_last)
                    state_next = ST_UP1;
                else if (cfg.n == CNT_W'(1))
                    state_next = ST_DONE;
                else
                    state_next = ST_LVL;
            end
            ST_LVL:    state_next = ST_LEFT;
            ST_LEFT:   state_next = ST_RD;
            ST_RD:     state_next = ST_SUM;
            ST_SUM:    state_next = ST_NODE_W;
            ST_NODE_W:
            begin
                if (mul_rsp.done)
                begin
                    if (!node_last)
                        state_next = ST_RD;
                    else if (lvl_reg == ADDR_W'(1))
                        state_next = ST_DONE;
                    else
                        state_next = ST_LVL;
                end
            end
            ST_DONE:   if (res_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs: memory port, multiplier request, handshakes.
    always_comb
    begin
        ram_req.we    = 1'b0;
        ram_req.waddr = idx_reg;
        ram_req.wdata = leaf_val;
        ram_req.raddr = '0;
        mul_req.start = 1'b0;
        mul_req.sh    = SH_UP;
        mul_req.a     = {1'b0, p_reg};
        mul_req.f     = cfg.up;
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_DOWN:
            begin
                mul_req.start = (cnt_reg != n_m1);
                mul_req.sh    = SH_DOWN;
                mul_req.f     = cfg.down;
            end
            ST_UP1, ST_UP2: mul_req.start = 1'b1;
            ST_LEAF: ram_req.we = 1'b1;
            ST_LVL:  ram_req.raddr = '0;
            ST_RD:   ram_req.raddr = idx_reg + ADDR_W'(1);
            ST_SUM:
            begin
                mul_req.start = 1'b1;
                mul_req.sh    = SH_DISC;
                mul_req.a     = {1'b0, left_reg} + {1'b0, rdata};
                mul_req.f     = cfg.hdisc;
            end
            ST_NODE_W:
            begin
                ram_req.we    = mul_rsp.done;
                ram_req.wdata = mul_rsp.value;
            end
            ST_DONE: res_valid = 1'b1;
            default: ;
        endcase
    end

    // State register and loop counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            lvl_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    idx_reg <= '0;
                    ovf_reg <= 1'b0;
                end
                ST_DOWN_W:
                begin
                    if (mul_rsp.done)
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                        ovf_reg <= ovf_reg | mul_rsp.sat;
                    end
                end
                ST_UP1_W, ST_UP2_W:
                begin
                    if (mul_rsp.done)
                        ovf_reg <= ovf_reg | mul_rsp.sat;
                end
                ST_LEAF:
                begin
                    if (!leaf_last)
                    begin
                        idx_reg <= idx_reg + ADDR_W'(1);
                    end
                    else
                    begin
                        idx_reg <= '0;
                        lvl_reg <= n_m1[ADDR_W-1:0];
                    end
                end
                ST_NODE_W:
                begin
                    if (mul_rsp.done)
                    begin
                        ovf_reg <= ovf_reg | mul_rsp.sat;
                        if (!node_last)
                        begin
                            idx_reg <= idx_reg + ADDR_W'(1);
                        end
                        else
                        begin
                            idx_reg <= '0;
                            lvl_reg <= lvl_reg - ADDR_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    p_reg      <= spot;
                    strike_reg <= strike;
                end
            end
            ST_DOWN_W, ST_UP1_W, ST_UP2_W:
            begin
                if (mul_rsp.done)
                    p_reg <= mul_rsp.value;
            end
            ST_LEAF:  last_reg <= leaf_val;
            ST_LEFT:  left_reg <= rdata;
            ST_SUM:   right_reg <= rdata;
            ST_NODE_W:
            begin
                if (mul_rsp.done)
                begin
                    last_reg <= mul_rsp.value;
                    left_reg <= right_reg;
                end
            end
            default: ;
        endcase
    end

    // The last value written is the root.
    assign res_value = last_reg;
    assign res_ovf   = ovf_reg;

endmodule

// ===== rtl/binomial_option_pricer.sv =====
// Pricing time depends on the level count n, set by the pipelined multiplier and the node
// memory, one node at a time.
// One request is priced at a time, and a new request is accepted while the previous result
// waits in the output register.
// Reset (rst_n low, asynchronous) clears control state and loads the register
// defaults: up 1.0, down 1.0, half discount 0.5, one level. No memory clearing pass.
module binomial_option_pricer (
    input  logic                               clk,
    input  logic                               rst_n,
    // Input stream: spot [43:0], strike [87:44].
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [bop_pkg::IN_DATA_W-1:0]      s_tdata,
    // Output stream: option_value [43:0], zero pad [47:44].
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bop_pkg::OUT_DATA_W-1:0]     m_tdata,
    // Output flag: overflow [0].
    output logic                               m_tuser,
    // Configuration write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bop_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bop_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bop_pkg::*;

    logic [FACT_W-1:0]  up_reg;
    logic [FACT_W-1:0]  down_reg;
    logic [FACT_W-1:0]  hdisc_reg;
    logic [STEPS_W-1:0] steps_reg;
    cfg_t               cfg;

    logic               res_valid;
    logic               res_ready;
    logic [VAL_W-1:0]   res_value;
    logic               res_ovf;

    logic               out_valid_reg;
    logic [VAL_W-1:0]   out_value_reg;
    logic               out_ovf_reg;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_reg    <= UP_RESET;
            down_reg  <= DOWN_RESET;
            hdisc_reg <= HDISC_RESET;
            steps_reg <= STEPS_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_UP:    up_reg    <= cfg_data;
                CFG_DOWN:  down_reg  <= cfg_data;
                CFG_HDISC: hdisc_reg <= cfg_data;
                CFG_STEPS: steps_reg <= cfg_data[STEPS_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the level count to one through MAX_STEPS.
    always_comb
    begin
        cfg.up    = up_reg;
        cfg.down  = down_reg;
        cfg.hdisc = hdisc_reg;
        if (steps_reg == '0)
            cfg.n = CNT_W'(1);
        else if (CNT_W'(steps_reg) > CNT_W'(MAX_STEPS))
            cfg.n = CNT_W'(MAX_STEPS);
        else
            cfg.n = CNT_W'(steps_reg);
    end

    bop_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .spot      (s_tdata[VAL_W-1:0]),
        .strike    (s_tdata[2*VAL_W-1:VAL_W]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_value (res_value),
        .res_ovf   (res_ovf)
    );

    // Output register decouples the result from the downstream transaction.
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_value_reg <= res_value;
            out_ovf_reg   <= res_ovf;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-VAL_W){1'b0}}, out_value_reg};
    assign m_tuser  = out_ovf_reg;

endmodule

// ===== dv/tb_binomial_option_pricer.sv =====
// Self-checking testbench for the binomial option pricer: streams quotes, predicts each root value.
module tb_binomial_option_pricer;

    import bop_pkg::*;

    // Fraction bits of each factor register.
    localparam int UP_FRAC   = 30;
    localparam int DOWN_FRAC = 31;
    localparam int DISC_FRAC = 32;

    // Percentage of cycles in which either side idles.
    localparam int IDLE_PCT = 11;

    // Accepted-quote window in which neither side idles.
    localparam int CALM_LO = 40;
    localparam int CALM_HI = 70;

    // Two full-size trees dominate the run; the rest is small.
    localparam int unsigned CYCLE_LIMIT = 40_000_000;
    localparam int TAIL_CYCLES = 200;

    typedef enum {
        SK_PRICE,
        SK_CFG,
        SK_DRAIN
    } stim_kind_t;

    typedef struct {
        stim_kind_t            kind;
        logic [VAL_W-1:0]      spot;
        logic [VAL_W-1:0]      strike;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } stim_t;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             ovf;
    } quote_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Handshakes seen at the last rising edge.
    logic in_taken  = 1'b0;
    logic cfg_taken = 1'b0;

    // Shadow copy of the pricer registers.
    logic [FACT_W-1:0]  up_f    = UP_RESET;
    logic [FACT_W-1:0]  down_f  = DOWN_RESET;
    logic [FACT_W-1:0]  hdisc_f = HDISC_RESET;
    logic [STEPS_W-1:0] steps_r = STEPS_RESET;

    logic [VAL_W-1:0] tree_vals [MAX_STEPS];

    stim_t       stim_q[$];
    quote_t      quote_q[$];
    int          err_cnt  = 0;
    int          items_in = 0;
    int unsigned cycles   = 0;

    binomial_option_pricer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Truncating fixed-point multiply, saturated to the value width.
    function automatic logic [VAL_W-1:0] scale_sat(input logic [SUM_W-1:0] a,
                                                   input logic [FACT_W-1:0] f,
                                                   input int sh, output logic hit);
        logic [PROD_W-1:0] prod;
        logic [PROD_W-1:0] r;
        prod = a * f;
        r    = prod >> sh;
        hit  = (r > VAL_MAX);
        return hit ? VAL_MAX : r[VAL_W-1:0];
    endfunction

    // Root value of a European call on the current tree configuration.
    function automatic quote_t price_call(input logic [VAL_W-1:0] spot,
                                          input logic [VAL_W-1:0] strike);
        quote_t           q;
        int               n;
        int               i;
        int               j;
        logic [VAL_W-1:0] p;
        logic [SUM_W-1:0] s;
        logic             hit;
        logic             sat;
        sat = 1'b0;
        n   = int'(steps_r);
        if (n == 0)
            n = 1;
        if (n > MAX_STEPS)
            n = MAX_STEPS;
        // Lowest leaf price, then climb two up moves per leaf.
        p = spot;
        for (i = 1; i < n; i++)
        begin
            p   = scale_sat({1'b0, p}, down_f, DOWN_FRAC, hit);
            sat = sat | hit;
        end
        for (j = 0; j < n; j++)
        begin
            if (j > 0)
            begin
                p   = scale_sat({1'b0, p}, up_f, UP_FRAC, hit);
                sat = sat | hit;
                p   = scale_sat({1'b0, p}, up_f, UP_FRAC, hit);
                sat = sat | hit;
            end
            tree_vals[j] = (p > strike) ? p - strike : '0;
        end
        // Backward induction down to the root.
        for (i = n - 1; i > 0; i--)
        begin
            for (j = 0; j < i; j++)
            begin
                s            = {1'b0, tree_vals[j]} + {1'b0, tree_vals[j + 1]};
                tree_vals[j] = scale_sat(s, hdisc_f, DISC_FRAC, hit);
                sat          = sat | hit;
            end
        end
        q.value = tree_vals[0];
        q.ovf   = sat;
        return q;
    endfunction

    function automatic logic [VAL_W-1:0] rand_val();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[VAL_W-1:0];
    endfunction

    // Whole number of currency units in Q20.24.
    function automatic logic [VAL_W-1:0] q_int(input int unsigned x);
        return {x[19:0], 24'd0};
    endfunction

    task automatic add_price(input logic [VAL_W-1:0] spot, input logic [VAL_W-1:0] strike);
        stim_t e;
        e.kind   = SK_PRICE;
        e.spot   = spot;
        e.strike = strike;
        e.idx    = CFG_UP;
        e.data   = '0;
        stim_q.push_back(e);
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        stim_t e;
        e.kind   = SK_CFG;
        e.spot   = '0;
        e.strike = '0;
        e.idx    = idx;
        e.data   = data;
        stim_q.push_back(e);
    endtask

    task automatic add_drain();
        stim_t e;
        e.kind   = SK_DRAIN;
        e.spot   = '0;
        e.strike = '0;
        e.idx    = CFG_UP;
        e.data   = '0;
        stim_q.push_back(e);
    endtask

    task automatic add_setup(input logic [31:0] up, input logic [31:0] down,
                             input logic [31:0] hd, input logic [31:0] n);
        add_cfg(CFG_UP, up);
        add_cfg(CFG_DOWN, down);
        add_cfg(CFG_HDISC, hd);
        add_cfg(CFG_STEPS, n);
    endtask

    // Random tree: up and down factors mostly near 1.0, half discount mostly near 0.5, small trees mostly.
    task automatic add_random_setup();
        logic [31:0] up;
        logic [31:0] down;
        logic [31:0] hd;
        logic [31:0] n;
        int          pick;
        if ($urandom_range(3) == 0)
            up = $urandom_range(32'hFFFF_FFFF, 32'h4000_0000);
        else
            up = 32'h4000_0000 + $urandom_range(32'h0100_0000, 0);
        if ($urandom_range(3) == 0)
            down = $urandom_range(32'h8000_0000, 0);
        else
            down = 32'h8000_0000 - $urandom_range(32'h0100_0000, 0);
        if ($urandom_range(3) == 0)
            hd = $urandom_range(32'h8000_0000, 0);
        else
            hd = 32'h8000_0000 - $urandom_range(32'h0040_0000, 0);
        pick = $urandom_range(15);
        if (pick == 0)
            n = 0;
        else if (pick < 3)
            n = $urandom_range(40, 13);
        else
            n = $urandom_range(12, 1);
        add_setup(up, down, hd, n);
    endtask

    task automatic add_random_price();
        logic [VAL_W-1:0] spot;
        logic [VAL_W-1:0] strike;
        int unsigned      whole;
        int               k;
        case ($urandom_range(2))
            0:
            begin
                spot   = rand_val();
                strike = rand_val();
            end
            1:
            begin
                // Strike close to spot, both in a realistic price range.
                whole  = $urandom_range(2000, 1);
                k      = int'(whole) + int'($urandom_range(40, 0)) - 20;
                if (k < 0)
                    k = 0;
                spot   = {whole[19:0], 24'($urandom)};
                strike = {20'(k), 24'($urandom)};
            end
            default:
            begin
                spot   = rand_val();
                strike = rand_val() >> $urandom_range(43, 0);
            end
        endcase
        add_price(spot, strike);
    endtask

    // Stimulus, reset and end of run.
    initial
    begin
        int n_rand;
        int k;
        int i;

        // Register defaults: one level, so the root is the intrinsic value.
        add_price('0, '0);
        add_price(VAL_MAX, '0);
        add_price('0, VAL_MAX);
        add_price(VAL_MAX, VAL_MAX);
        add_price(q_int(100), q_int(90));
        add_price(q_int(90), q_int(100));

        // Zero levels behave as one.
        add_cfg(CFG_STEPS, 32'd0);
        add_price(q_int(50), q_int(20));
        add_price(VAL_MAX, 44'd1);

        // Largest up factor: leaf prices saturate for large spots.
        add_setup(32'hFFFF_FFFF, DOWN_RESET, HDISC_RESET, 32'd4);
        add_price(VAL_MAX, '0);
        add_price(q_int(1000), '0);
        add_price(44'd1, '0);

        // Zero down factor and zero discount.
        add_setup(32'h4000_0000, 32'd0, 32'd0, 32'd3);
        add_price(q_int(100), q_int(50));
        add_price(VAL_MAX, '0);

        // Factors beyond their range: down near 2.0, discount near 1.0.
        add_setup(32'h4000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd5);
        add_price(44'h100_0000_0000, '0);
        add_price(q_int(1), '0);

        // Realistic small tree, with a full drain in the middle.
        add_setup(32'd1084479242, 32'd2126221483, 32'd2147054216, 32'd8);
        add_price(q_int(100), q_int(100));
        add_price(q_int(100), q_int(80));
        add_drain();
        add_price(q_int(100), q_int(120));

        // Random phases.
        n_rand = 0;
        while (n_rand < 80)
        begin
            add_random_setup();
            k = $urandom_range(12, 4);
            for (i = 0; i < k; i++)
            begin
                add_random_price();
                if ($urandom_range(7) == 0)
                    add_drain();
            end
            n_rand += k;
        end

        // Full-size tree, then a step count above the maximum.
        add_setup(32'h4010_0000, 32'h7FE0_0000, 32'h7FFF_0000, 32'd1024);
        add_price(q_int(100), q_int(100));
        add_cfg(CFG_STEPS, 32'd2047);
        add_price(q_int(100), q_int(95));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (stim_q.size() != 0 || s_tvalid || cfg_valid)
            @(negedge clk);
        while (quote_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Driver: presents the head of the stimulus queue and the output ready.
    always @(negedge clk)
    begin
        logic                  nxt_sv;
        logic [IN_DATA_W-1:0]  nxt_sd;
        logic                  nxt_cv;
        logic [CFG_IDX_W-1:0]  nxt_ci;
        logic [CFG_DATA_W-1:0] nxt_cd;
        logic                  nxt_mr;
        logic                  calm;
        logic                  go;
        nxt_sv = s_tvalid;
        nxt_sd = s_tdata;
        nxt_cv = cfg_valid;
        nxt_ci = cfg_index;
        nxt_cd = cfg_data;
        nxt_mr = 1'b0;
        calm   = (items_in >= CALM_LO) && (items_in < CALM_HI);
        if (rst_n)
        begin
            // Retire the transaction taken at the last rising edge.
            if ((s_tvalid && in_taken) || (cfg_valid && cfg_taken))
            begin
                void'(stim_q.pop_front());
                nxt_sv = 1'b0;
                nxt_cv = 1'b0;
            end
            go = calm || ($urandom_range(99) >= IDLE_PCT);
            if (!nxt_sv && !nxt_cv && stim_q.size() != 0 && go)
            begin
                case (stim_q[0].kind)
                    SK_PRICE:
                    begin
                        nxt_sv = 1'b1;
                        nxt_sd = {stim_q[0].strike, stim_q[0].spot};
                    end
                    SK_CFG:
                    begin
                        // Registers change only while nothing is in flight.
                        if (quote_q.size() == 0)
                        begin
                            nxt_cv = 1'b1;
                            nxt_ci = stim_q[0].idx;
                            nxt_cd = stim_q[0].data;
                        end
                    end
                    default:
                    begin
                        if (quote_q.size() == 0)
                            void'(stim_q.pop_front());
                    end
                endcase
            end
            nxt_mr = calm || ($urandom_range(99) >= IDLE_PCT);
        end
        s_tvalid  <= nxt_sv;
        s_tdata   <= nxt_sd;
        cfg_valid <= nxt_cv;
        cfg_index <= nxt_ci;
        cfg_data  <= nxt_cd;
        m_tready  <= nxt_mr;
    end

    // Monitor: tracks register writes, predicts quotes and checks results.
    always @(posedge clk)
    begin
        quote_t want;
        if (rst_n)
        begin
            in_taken  <= s_tvalid && s_tready;
            cfg_taken <= cfg_valid && cfg_ready;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_UP:    up_f    = cfg_data;
                    CFG_DOWN:  down_f  = cfg_data;
                    CFG_HDISC: hdisc_f = cfg_data;
                    CFG_STEPS: steps_r = cfg_data[STEPS_W-1:0];
                    default:   ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                quote_q.push_back(price_call(s_tdata[VAL_W-1:0], s_tdata[2*VAL_W-1:VAL_W]));
                items_in <= items_in + 1;
            end
            if (m_tvalid && m_tready)
            begin
                if (quote_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual value %h flag %b",
                             $time, m_tdata, m_tuser);
                    err_cnt++;
                end
                else
                begin
                    want = quote_q.pop_front();
                    if (m_tdata[VAL_W-1:0] !== want.value)
                    begin
                        $display("%0t: option_value mismatch, expected %h, actual %h",
                                 $time, want.value, m_tdata[VAL_W-1:0]);
                        err_cnt++;
                    end
                    if (m_tdata[OUT_DATA_W-1:VAL_W] !== '0)
                    begin
                        $display("%0t: pad bits mismatch, expected 0, actual %h",
                                 $time, m_tdata[OUT_DATA_W-1:VAL_W]);
                        err_cnt++;
                    end
                    if (m_tuser !== want.ovf)
                    begin
                        $display("%0t: overflow mismatch, expected %b, actual %b",
                                 $time, want.ovf, m_tuser);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("%0t: run limit reached with %0d results outstanding",
                     $time, quote_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule
